@@ rtl/core/sact_pkg.sv @@
// ----------------------------------------------------------------------------
// sact_pkg
// Types and constants shared by the cache tag directory and replacement engine
// ----------------------------------------------------------------------------
package sact_pkg;

  localparam int DefNumSets = 64;
  localparam int DefNumWays = 4;

  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 4;
  localparam int AddrW     = 32;
  localparam int RandW     = 16;
  localparam int TagW      = 32;
  localparam int MaxOffset = 8;

  localparam logic [CfgIdxW-1:0] CFG_POLICY     = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_LINE_SHIFT = 1'b1;

  localparam logic [1:0] POL_LRU = 2'd0;
  localparam logic [1:0] POL_MRU = 2'd1;

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] random_value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  way;
    logic [5:0]  set_index;
    logic [7:0]  block_offset;
    logic [31:0] access_total;
    logic [31:0] miss_total;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
  } ctrl_t;

endpackage

@@ rtl/core/set_assoc_cache_tag_replacement.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_replacement
// Tag directory and LRU/MRU/random replacement engine of a set-assoc cache
// ----------------------------------------------------------------------------
// One access at a time: start is taken when busy is low, the set's tags,
// valid bits and recency list are read in the next cycle, and the update is
// written back in the cycle after, one set row read then written back per
// access; the result strobe done is registered from the update step.
// done is high for one cycle and cannot be held off by the receiver.
// Configuration writes take effect at once; the user must make them only while idle, the block does not enforce this.
module set_assoc_cache_tag_replacement #(
  parameter int SET_COUNT = sact_pkg::DefNumSets,
  parameter int NUM_WAYS  = sact_pkg::DefNumWays
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  sact_pkg::req_t                req,
  output logic                          done,
  output sact_pkg::rsp_t                rsp,
  input  logic                          cfg_we,
  input  logic [sact_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sact_pkg::CfgDataW-1:0] cfg_data
);
  import sact_pkg::*;

  ctrl_t      ctrl;
  logic [1:0] policy;
  logic [3:0] line_shift;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= POL_LRU;
      line_shift <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY:     policy     <= cfg_data[1:0];
        CFG_LINE_SHIFT: line_shift <= cfg_data;
        default: ;
      endcase
    end
  end

  sact_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .ctrl (ctrl)
  );

  sact_dp #(.SET_COUNT(SET_COUNT), .NUM_WAYS(NUM_WAYS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .req         (req),
    .policy      (policy),
    .line_shift  (line_shift),
    .result_valid(done),
    .result      (rsp)
  );

  // a result follows each update step
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    ctrl.update |=> done) else $error("missing result");
  // capture only when idle
  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.capture |-> !busy) else $error("capture while busy");
  // miss total stays as it was on a hit result
  a_miss_step: assert property (@(posedge clk) disable iff (rst)
    done && rsp.hit |-> rsp.miss_total == $past(rsp.miss_total) || $past(rst))
    else $error("miss count moved on hit");

endmodule

@@ rtl/core/sact_ctrl.sv @@
// ----------------------------------------------------------------------------
// sact_ctrl
// Sequencer: capture, tag/recency lookup, then update and result strobe
// ----------------------------------------------------------------------------
module sact_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output sact_pkg::ctrl_t ctrl
);
  import sact_pkg::*;

  typedef enum logic [1:0] {IDLE, LOOKUP, UPDATE} state_t;
  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE:    if (start) state <= LOOKUP;
        LOOKUP:  state <= UPDATE;
        UPDATE:  state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  assign busy         = (state != IDLE);
  assign ctrl.capture = (state == IDLE) && start;
  assign ctrl.lookup  = (state == LOOKUP);
  assign ctrl.update  = (state == UPDATE);

endmodule

@@ rtl/core/sact_dp.sv @@
// ----------------------------------------------------------------------------
// sact_dp
// Datapath: address split, tag and recency memories, victim choice, counters
// ----------------------------------------------------------------------------
module sact_dp #(
  parameter int SET_COUNT = sact_pkg::DefNumSets,
  parameter int NUM_WAYS  = sact_pkg::DefNumWays
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sact_pkg::ctrl_t           ctrl,
  input  sact_pkg::req_t            req,
  input  logic [1:0]                policy,
  input  logic [3:0]                line_shift,
  output logic                      result_valid,
  output sact_pkg::rsp_t            result
);
  import sact_pkg::*;

  localparam int SB   = (SET_COUNT > 1) ? $clog2(SET_COUNT + 1) - 1 : 0;
  localparam int SW   = (SB > 0) ? SB : 1;
  localparam int WB   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int ROWS = 1 << SB;
  localparam int RW   = NUM_WAYS * WB;

  typedef logic [TagW-1:0] tag_t;

  // captured item
  logic [AddrW-1:0] addr;
  logic [RandW-1:0] rnd;
  logic             tracked;

  // address split
  logic [3:0]    ob;
  logic [SW-1:0] set_idx;
  tag_t          tag;
  logic [7:0]    offset;
  logic [AddrW-1:0] shifted;
  always_comb begin
    ob      = (line_shift > 4'(MaxOffset)) ? 4'(MaxOffset) : line_shift;
    shifted = addr >> ob;
    set_idx = (SB > 0) ? SW'(shifted) : '0;
    tag     = TagW'(shifted >> SB);
    offset  = 8'(addr & ((AddrW'(1) << ob) - AddrW'(1)));
  end

  // tag and recency memories, one row per set
  tag_t          tag_mem [ROWS][NUM_WAYS];
  logic [RW-1:0] rec_mem [ROWS];
  logic [NUM_WAYS-1:0] valid_bits [ROWS];
  tag_t          tag_rd [NUM_WAYS];
  logic [RW-1:0] rec_rd;
  logic [NUM_WAYS-1:0] valid_rd;
  logic          rec_init;

  // lookup results
  logic          hit;
  logic [WB-1:0] hit_way, free_way, way_sel;
  logic          free_found;

  always_ff @(posedge clk) begin
    if (ctrl.lookup) begin
      for (int w = 0; w < NUM_WAYS; w++) tag_rd[w] <= tag_mem[set_idx][w];
      rec_rd   <= rec_mem[set_idx];
    end
  end

  // valid bits and recency-initialised marks reset at once
  logic [ROWS-1:0] rec_ok;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < ROWS; s++) valid_bits[s] <= '0;
      rec_ok <= '0;
    end else if (ctrl.update) begin
      valid_bits[set_idx][way_sel] <= 1'b1;
      if (tracked) rec_ok[set_idx] <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (ctrl.lookup) begin
      valid_rd <= valid_bits[set_idx];
      rec_init <= rec_ok[set_idx];
    end
  end

  // recency list as read, with reset order where untouched
  logic [WB-1:0] order [NUM_WAYS];
  always_comb begin
    for (int i = 0; i < NUM_WAYS; i++)
      order[i] = rec_init ? rec_rd[i*WB +: WB] : WB'(i);
  end

  // hit search and first free way
  always_comb begin
    hit = 1'b0; hit_way = '0; free_found = 1'b0; free_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (valid_rd[w] && tag_rd[w] == tag) begin
        hit = 1'b1; hit_way = WB'(w);
      end
      if (!valid_rd[w]) begin
        free_found = 1'b1; free_way = WB'(w);
      end
    end
    if (hit)                  way_sel = hit_way;
    else if (free_found)      way_sel = free_way;
    else if (policy == POL_LRU) way_sel = order[NUM_WAYS-1];
    else if (policy == POL_MRU) way_sel = order[0];
    else                      way_sel = WB'(rnd % RandW'(NUM_WAYS));
  end

  // move to front
  logic [RW-1:0] rec_new;
  logic          seen;
  always_comb begin
    seen = 1'b0;
    rec_new = '0;
    rec_new[0 +: WB] = way_sel;
    for (int i = 1; i < NUM_WAYS; i++) begin
      if (order[i-1] == way_sel) seen = 1'b1;
      rec_new[i*WB +: WB] = seen ? order[i] : order[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      if (!hit) tag_mem[set_idx][way_sel] <= tag;
      if (tracked) rec_mem[set_idx] <= rec_new;
    end
  end

  // capture and counters
  logic [31:0] acc_cnt, miss_cnt;
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      addr    <= req.address;
      rnd     <= req.random_value;
      tracked <= (policy == POL_LRU) || (policy == POL_MRU);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_cnt      <= '0;
      miss_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctrl.update;
      if (ctrl.update) begin
        acc_cnt  <= acc_cnt + 32'd1;
        if (!hit) miss_cnt <= miss_cnt + 32'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      result.hit          <= hit;
      result.way          <= 2'(way_sel);
      result.set_index    <= 6'(set_idx);
      result.block_offset <= offset;
      result.access_total <= acc_cnt + 32'd1;
      result.miss_total   <= miss_cnt + (hit ? 32'd0 : 32'd1);
    end
  end

endmodule

@@ tb/sv/tb_set_assoc_cache_tag_replacement.sv @@
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_replacement
// Drives read accesses through the tag directory under each replacement
// policy and several line sizes, predicts hit, way, set, offset and counters, and
// checks every result strobe against the oldest expected access result
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_tag_replacement;
  timeunit 1ns;
  timeprecision 1ps;
  import sact_pkg::*;

  localparam int NSETS = 64;
  localparam int NWAYS = 4;
  localparam logic [1:0] POL_RANDOM = 2'd2;
  localparam logic [1:0] POL_RANDOM_ALT = 2'd3;

  // access predictor and queue of expected results
  class cache_scoreboard;
    bit          valid_q[NSETS][NWAYS];
    logic [31:0] tag_q[NSETS][NWAYS];
    logic [1:0]  order_q[NSETS][NWAYS];
    logic [31:0] accesses;
    logic [31:0] misses;
    logic [1:0]  pol;
    logic [3:0]  obits;
    rsp_t        pending[$];
    int          errors;

    function void clear();
      foreach (valid_q[s, w]) begin
        valid_q[s][w] = 0;
        tag_q[s][w] = '0;
        order_q[s][w] = w[1:0];
      end
      accesses = 0;
      misses = 0;
      pol = POL_LRU;
      obits = 4'd3;
      errors = 0;
    endfunction

    function void touch(int s, logic [1:0] w);
      int pos;
      pos = 0;
      for (int i = 0; i < NWAYS; i++)
        if (order_q[s][i] == w) begin
          pos = i;
          break;
        end
      for (int i = pos; i > 0; i--) order_q[s][i] = order_q[s][i-1];
      order_q[s][0] = w;
    endfunction

    // note an accepted access and queue its expected result
    function void note_access(req_t r);
      int ob, s;
      logic [31:0] tg;
      bit tracked, found;
      rsp_t e;
      ob = (obits > 8) ? 8 : obits;
      s = (r.address >> ob) & (NSETS - 1);
      tg = r.address >> (ob + 6);
      tracked = (pol == POL_LRU) || (pol == POL_MRU);
      e = '0;
      for (int i = 0; i < NWAYS; i++)
        if (!e.hit && valid_q[s][i] && tag_q[s][i] == tg) begin
          e.hit = 1;
          e.way = i[1:0];
        end
      accesses++;
      if (!e.hit) begin
        misses++;
        found = 0;
        for (int i = 0; i < NWAYS; i++)
          if (!found && !valid_q[s][i]) begin
            found = 1;
            e.way = i[1:0];
          end
        if (!found) begin
          if (pol == POL_LRU) e.way = order_q[s][NWAYS-1];
          else if (pol == POL_MRU) e.way = order_q[s][0];
          else e.way = r.random_value[1:0];
        end
        tag_q[s][e.way] = tg;
        valid_q[s][e.way] = 1;
      end
      if (tracked) touch(s, e.way);
      e.set_index = s[5:0];
      e.block_offset = 8'(r.address & ((32'd1 << ob) - 32'd1));
      e.access_total = accesses;
      e.miss_total = misses;
      pending.push_back(e);
    endfunction

    // compare one result strobe with the oldest expectation
    function void check_result(rsp_t a);
      rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.hit !== e.hit) begin
        $error("hit exp %0d got %0d", e.hit, a.hit); errors++;
      end
      if (a.way !== e.way) begin
        $error("way exp %0d got %0d", e.way, a.way); errors++;
      end
      if (a.set_index !== e.set_index) begin
        $error("set_index exp %0d got %0d", e.set_index, a.set_index); errors++;
      end
      if (a.block_offset !== e.block_offset) begin
        $error("block_offset exp %0d got %0d", e.block_offset, a.block_offset);
        errors++;
      end
      if (a.access_total !== e.access_total) begin
        $error("access_total exp %0d got %0d", e.access_total, a.access_total);
        errors++;
      end
      if (a.miss_total !== e.miss_total) begin
        $error("miss_total exp %0d got %0d", e.miss_total, a.miss_total);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done, cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  req_t req;
  rsp_t rsp;
  cache_scoreboard sb;
  logic [31:0] tag_pool[8];

  set_assoc_cache_tag_replacement DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(rsp);
  end

  // idle gap before the next access, start dropped while waiting
  task automatic idle_gap();
    int n;
    if ($urandom_range(0, 2) == 0) n = 0;
    else if ($urandom_range(0, 19) == 0) n = $urandom_range(10, 40);
    else n = $urandom_range(1, 3);
    if (n > 0) start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // present one access and hold it until taken
  task automatic send_access(logic [31:0] a, logic [15:0] rv);
    req_t r;
    r.address = a;
    r.random_value = rv;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    sb.note_access(r);
  endtask

  // wait until all results are in, then let the block settle
  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (sb.pending.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POLICY) sb.pol = d[1:0];
    else sb.obits = d;
  endtask

  // address built from a small tag pool so that sets fill and evict
  function automatic logic [31:0] pool_addr(int ob);
    logic [31:0] t, s, o;
    t = tag_pool[$urandom_range(0, 7)];
    s = $urandom_range(0, 3);
    o = $urandom;
    return (t << (ob + 6)) | (s << ob) | (o & ((32'd1 << ob) - 1));
  endfunction

  initial begin
    logic [3:0] ob_list[6];
    logic [1:0] pol_list[6];
    int ob;
    sb = new();
    sb.clear();
    start = 0;
    req = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, fill then evict one set under each policy
    send_access(32'h0000_0000, 16'h0000);
    send_access(32'hFFFF_FFFF, 16'hFFFF);
    send_access(32'h0000_0000, 16'h0000);
    foreach (pol_list[i]) pol_list[i] = POL_LRU;
    for (int p = 0; p < 4; p++) begin
      drain();
      write_reg(CFG_POLICY, p[3:0]);
      for (int k = 0; k < 5; k++)
        send_access({k[3:0] + 4'd4 * p[3:0], 19'd0, 9'd40}, 16'hAAAA >> k);
    end
    drain();
    write_reg(CFG_LINE_SHIFT, 4'd15);
    send_access(32'h8000_0123, 16'h5555);
    drain();
    write_reg(CFG_LINE_SHIFT, 4'd0);
    send_access(32'h8000_0123, 16'h5555);

    // random phases across policies and line sizes
    ob_list = '{4'd0, 4'd8, 4'd3, 4'd12, 4'd5, 4'd1};
    pol_list = '{POL_LRU, POL_MRU, POL_RANDOM, POL_RANDOM_ALT, POL_LRU, POL_MRU};
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(CFG_POLICY, {2'b00, pol_list[ph]});
      write_reg(CFG_LINE_SHIFT, ob_list[ph]);
      ob = (ob_list[ph] > 8) ? 8 : ob_list[ph];
      foreach (tag_pool[i]) tag_pool[i] = $urandom;
      for (int n = 0; n < 155; n++) begin
        idle_gap();
        if ($urandom_range(0, 9) < 8) send_access(pool_addr(ob), $urandom);
        else send_access($urandom, $urandom);
      end
    end

    drain();
    if (sb.pending.size() == 0 && sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
